// ===== sv/rbs_pkg.sv =====
// Package for the ray/box slab intersection block.
// Holds the default number format shared by the top level and its checker.
package rbs_pkg;

  // Default fixed-point format: Q16.16 in a 32-bit word.
  localparam int COORD_WIDTH_DEF   = 32;
  localparam int FRACTION_BITS_DEF = 16;

endpackage

// ===== sv/ray_box_slab_intersect.sv =====
// 2D ray against axis-aligned box slab test, fully pipelined.
// Depends on rbs_pkg for the default number format and on rbs_div.
//
// Usage: one item on the in_ channel carries a box, a ray origin and
// direction and a limit on the entry distance, all signed fixed point.
// Each item produces exactly one item on the out_ channel: the hit flag,
// the entry distance and the hit point (all zero on a miss).
// Both channels use valid/ready; an item moves when both are high.
// Most of the pipeline lies in the divider, which resolves one quotient
// bit per stage in four parallel lanes; the default format is Q16.16.
// A new item is accepted every cycle unless a stall has filled every stage.
// Each stage holds its own valid bit and advances whenever it is empty or
// the stage after it advances, so bubbles close up and an item can enter
// while a finished result still waits at the output.
// When out_ready is low the output holds and stages fill from the back;
// in_ready falls only once every stage holds an item.
// Synchronous active-low reset clears all valid bits; no data is reset.
module ray_box_slab_intersect #(
  parameter int COORD_WIDTH   = rbs_pkg::COORD_WIDTH_DEF,
  parameter int FRACTION_BITS = rbs_pkg::FRACTION_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [COORD_WIDTH-1:0] in_box_left,
  input  logic signed [COORD_WIDTH-1:0] in_box_right,
  input  logic signed [COORD_WIDTH-1:0] in_box_bottom,
  input  logic signed [COORD_WIDTH-1:0] in_box_top,
  input  logic signed [COORD_WIDTH-1:0] in_origin_x,
  input  logic signed [COORD_WIDTH-1:0] in_origin_y,
  input  logic signed [COORD_WIDTH-1:0] in_direction_x,
  input  logic signed [COORD_WIDTH-1:0] in_direction_y,
  input  logic signed [COORD_WIDTH-1:0] in_distance_limit,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_hit,
  output logic signed [COORD_WIDTH-1:0] out_entry_distance,
  output logic signed [COORD_WIDTH-1:0] out_point_x,
  output logic signed [COORD_WIDTH-1:0] out_point_y
);

  import rbs_pkg::*;

  localparam int CW  = COORD_WIDTH;
  localparam int FB  = FRACTION_BITS;
  localparam int DL  = CW + 2;
  localparam int L   = DL + 4;
  localparam int SBW = 3 + 5 * CW;
  localparam int PW  = 2 * CW;

  localparam logic signed [CW-1:0] V_MAX = {1'b0, {(CW-1){1'b1}}};
  localparam logic signed [CW-1:0] V_MIN = {1'b1, {(CW-1){1'b0}}};

  logic [L-1:0] v_r;
  logic [L-1:0] en;

  // Stage advance chain, from the output backwards.
  assign en[L-1] = !v_r[L-1] || out_ready;
  for (genvar k = 0; k < L - 1; k++) begin : g_en
    assign en[k] = !v_r[k] || en[k+1];
  end
  assign in_ready = en[0];

  // Valid bits travel with the data.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[0]) begin
        v_r[0] <= in_valid;
      end
      for (int k = 1; k < L; k++) begin
        if (en[k]) begin
          v_r[k] <= v_r[k-1];
        end
      end
    end
  end

  // Input stage.
  logic signed [CW-1:0] bl_r, br_r, bb_r, bt_r, ox_r, oy_r, dx_r, dy_r, lim_r;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      bl_r  <= in_box_left;
      br_r  <= in_box_right;
      bb_r  <= in_box_bottom;
      bt_r  <= in_box_top;
      ox_r  <= in_origin_x;
      oy_r  <= in_origin_y;
      dx_r  <= in_direction_x;
      dy_r  <= in_direction_y;
      lim_r <= in_distance_limit;
    end
  end

  // Edge distances, sign-extended by one bit.
  logic signed [CW:0] nxl, nxr, nyb, nyt;
  assign nxl = (CW+1)'(bl_r) - (CW+1)'(ox_r);
  assign nxr = (CW+1)'(br_r) - (CW+1)'(ox_r);
  assign nyb = (CW+1)'(bb_r) - (CW+1)'(oy_r);
  assign nyt = (CW+1)'(bt_r) - (CW+1)'(oy_r);

  // Zero-direction axes and their slab misses.
  logic zx, zy, miss;
  assign zx   = (dx_r == '0);
  assign zy   = (dy_r == '0);
  assign miss = (zx && (ox_r < bl_r || ox_r > br_r)) ||
                (zy && (oy_r < bb_r || oy_r > bt_r));

  logic signed [CW-1:0] qxa, qxb, qya, qyb;

  rbs_div #(.COORD_WIDTH(CW), .FRACTION_BITS(FB)) u_div_xa (
    .clk(clk), .en(en[DL:1]), .num(nxl), .den(dx_r), .quo(qxa));
  rbs_div #(.COORD_WIDTH(CW), .FRACTION_BITS(FB)) u_div_xb (
    .clk(clk), .en(en[DL:1]), .num(nxr), .den(dx_r), .quo(qxb));
  rbs_div #(.COORD_WIDTH(CW), .FRACTION_BITS(FB)) u_div_ya (
    .clk(clk), .en(en[DL:1]), .num(nyb), .den(dy_r), .quo(qya));
  rbs_div #(.COORD_WIDTH(CW), .FRACTION_BITS(FB)) u_div_yb (
    .clk(clk), .en(en[DL:1]), .num(nyt), .den(dy_r), .quo(qyb));

  // Side data delayed alongside the dividers.
  logic [SBW-1:0] sb_r [1:DL];

  always_ff @(posedge clk) begin
    if (en[1]) begin
      sb_r[1] <= {miss, zx, zy, ox_r, oy_r, dx_r, dy_r, lim_r};
    end
    for (int k = 2; k <= DL; k++) begin
      if (en[k]) begin
        sb_r[k] <= sb_r[k-1];
      end
    end
  end

  logic                 s_miss, s_zx, s_zy;
  logic signed [CW-1:0] s_ox, s_oy, s_dx, s_dy, s_lim;
  assign {s_miss, s_zx, s_zy, s_ox, s_oy, s_dx, s_dy, s_lim} = sb_r[DL];

  // Slab ordering, entry and exit, and the hit decision.
  logic signed [CW-1:0] xin, xout, yin, yout, ent, ext;
  logic                 hit;

  always_comb begin
    xin  = s_zx ? V_MIN : ((qxa < qxb) ? qxa : qxb);
    xout = s_zx ? V_MAX : ((qxa < qxb) ? qxb : qxa);
    yin  = s_zy ? V_MIN : ((qya < qyb) ? qya : qyb);
    yout = s_zy ? V_MAX : ((qya < qyb) ? qyb : qya);
    ent  = (xin > yin) ? xin : yin;
    ext  = (xout < yout) ? xout : yout;
    hit  = !s_miss && !(ext < 0) && !(ent > ext) && !(ent > s_lim);
  end

  logic                 e_hit_r;
  logic signed [CW-1:0] e_ent_r, e_ox_r, e_oy_r, e_dx_r, e_dy_r;

  always_ff @(posedge clk) begin
    if (en[DL+1]) begin
      e_hit_r <= hit;
      e_ent_r <= ent;
      e_ox_r  <= s_ox;
      e_oy_r  <= s_oy;
      e_dx_r  <= s_dx;
      e_dy_r  <= s_dy;
    end
  end

  // Products of direction and entry distance.
  logic                 p_hit_r;
  logic signed [CW-1:0] p_ent_r, p_ox_r, p_oy_r;
  logic signed [PW-1:0] p_px_r, p_py_r;

  always_ff @(posedge clk) begin
    if (en[DL+2]) begin
      p_hit_r <= e_hit_r;
      p_ent_r <= e_ent_r;
      p_ox_r  <= e_ox_r;
      p_oy_r  <= e_oy_r;
      p_px_r  <= e_dx_r * e_ent_r;
      p_py_r  <= e_dy_r * e_ent_r;
    end
  end

  // Floor to the fraction and add the origin with saturation.
  logic signed [PW:0] sum_x, sum_y;
  logic signed [CW-1:0] pt_x, pt_y;

  assign sum_x = (PW+1)'(p_px_r >>> FB) + (PW+1)'(p_ox_r);
  assign sum_y = (PW+1)'(p_py_r >>> FB) + (PW+1)'(p_oy_r);

  always_comb begin
    if (sum_x > (PW+1)'(V_MAX)) begin
      pt_x = V_MAX;
    end else if (sum_x < (PW+1)'(V_MIN)) begin
      pt_x = V_MIN;
    end else begin
      pt_x = sum_x[CW-1:0];
    end
    if (sum_y > (PW+1)'(V_MAX)) begin
      pt_y = V_MAX;
    end else if (sum_y < (PW+1)'(V_MIN)) begin
      pt_y = V_MIN;
    end else begin
      pt_y = sum_y[CW-1:0];
    end
  end

  // Output register; a miss reports zeros.
  logic                 o_hit_r;
  logic signed [CW-1:0] o_ent_r, o_px_r, o_py_r;

  always_ff @(posedge clk) begin
    if (en[L-1]) begin
      o_hit_r <= p_hit_r;
      o_ent_r <= p_hit_r ? p_ent_r : '0;
      o_px_r  <= p_hit_r ? pt_x : '0;
      o_py_r  <= p_hit_r ? pt_y : '0;
    end
  end

  assign out_valid          = v_r[L-1];
  assign out_hit            = o_hit_r;
  assign out_entry_distance = o_ent_r;
  assign out_point_x        = o_px_r;
  assign out_point_y        = o_py_r;

endmodule

// ===== sv/rbs_div.sv =====
// Pipelined fixed-point divider for the slab intersection block.
// One quotient bit per stage; uses no package items.
module rbs_div #(
  parameter int COORD_WIDTH   = 32,
  parameter int FRACTION_BITS = 16
) (
  input  logic                       clk,
  input  logic [COORD_WIDTH+1:0]     en,
  input  logic signed [COORD_WIDTH:0]   num,
  input  logic signed [COORD_WIDTH-1:0] den,
  output logic signed [COORD_WIDTH-1:0] quo
);

  localparam int CW = COORD_WIDTH;
  localparam int FB = FRACTION_BITS;
  localparam int NB = CW - 1;
  localparam int RW = 2 * CW + FB;

  logic [CW:0]   n0_r;
  logic [CW-1:0] d0_r;
  logic          neg0_r;

  logic [RW-1:0] rem_r [0:NB];
  logic [NB-1:0] q_r   [0:NB];
  logic [CW-1:0] d_r   [0:NB];
  logic          neg_r [0:NB];
  logic          ovf_r [0:NB];

  logic signed [CW-1:0] quo_r;

  // Stage one: magnitudes and the sign of the quotient.
  always_ff @(posedge clk) begin
    if (en[0]) begin
      n0_r   <= num[CW] ? (CW+1)'(-num) : num;
      d0_r   <= den[CW-1] ? CW'(-den) : den;
      neg0_r <= num[CW] ^ den[CW-1];
    end
  end

  // Stage two: the scaled dividend and the overflow test against the range.
  always_ff @(posedge clk) begin
    if (en[1]) begin
      rem_r[0] <= RW'(n0_r) << FB;
      ovf_r[0] <= (RW'(n0_r) << FB) >= (RW'(d0_r) << (CW - 1));
      q_r[0]   <= '0;
      d_r[0]   <= d0_r;
      neg_r[0] <= neg0_r;
    end
  end

  // Restoring division, most significant quotient bit first.
  for (genvar k = 0; k < NB; k++) begin : g_bit
    localparam int SH = NB - 1 - k;
    logic [RW:0] trial;

    assign trial = {1'b0, rem_r[k]} - ((RW+1)'(d_r[k]) << SH);

    always_ff @(posedge clk) begin
      if (en[k+2]) begin
        rem_r[k+1] <= trial[RW] ? rem_r[k] : trial[RW-1:0];
        q_r[k+1]   <= q_r[k] | (NB'(!trial[RW]) << SH);
        d_r[k+1]   <= d_r[k];
        neg_r[k+1] <= neg_r[k];
        ovf_r[k+1] <= ovf_r[k];
      end
    end
  end

  // Last stage: sign and saturation.
  always_ff @(posedge clk) begin
    if (en[CW+1]) begin
      if (ovf_r[NB]) begin
        quo_r <= neg_r[NB] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
      end else if (neg_r[NB]) begin
        quo_r <= -$signed({1'b0, q_r[NB]});
      end else begin
        quo_r <= $signed({1'b0, q_r[NB]});
      end
    end
  end

  assign quo = quo_r;

endmodule

// ===== sv/rbs_checker.sv =====
// Port-level checker for the slab intersection block, with its bind.
// Depends on rbs_pkg for the default coordinate width.
module rbs_checker #(
  parameter int COORD_WIDTH = rbs_pkg::COORD_WIDTH_DEF
) (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_ready,
  input logic                   out_valid,
  input logic                   out_ready,
  input logic                   out_hit,
  input logic [COORD_WIDTH-1:0] out_entry_distance,
  input logic [COORD_WIDTH-1:0] out_point_x,
  input logic [COORD_WIDTH-1:0] out_point_y
);

  // A stalled result item stays valid and keeps its entry distance.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_entry_distance))
    else $error("result item changed while stalled");

  // A miss carries zero distance and point.
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_hit |-> out_entry_distance == '0 &&
      out_point_x == '0 && out_point_y == '0)
    else $error("miss item with non-zero payload");

  // With the receiver ready the whole pipeline moves, so input is taken.
  a_flow: assert property (@(posedge clk) disable iff (!rst_n)
    out_ready |-> in_ready)
    else $error("input stalled while output is draining");

  // Reset empties the pipeline.
  a_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result item present after reset");

endmodule

bind ray_box_slab_intersect rbs_checker #(.COORD_WIDTH(COORD_WIDTH)) u_rbs_checker (
  .clk(clk),
  .rst_n(rst_n),
  .in_ready(in_ready),
  .out_valid(out_valid),
  .out_ready(out_ready),
  .out_hit(out_hit),
  .out_entry_distance(out_entry_distance),
  .out_point_x(out_point_x),
  .out_point_y(out_point_y)
);

// ===== tb/tb_ray_box_slab_intersect.sv =====
// Testbench for the ray/box slab intersection block.
// Depends on rbs_pkg and ray_box_slab_intersect; predicts every result itself
// and checks each output item against the oldest prediction.
module tb_ray_box_slab_intersect;
  import rbs_pkg::*;

  localparam int W = COORD_WIDTH_DEF;
  localparam int F = FRACTION_BITS_DEF;
  localparam longint VMAX = (longint'(1) <<< (W - 1)) - 1;
  localparam longint VMIN = -(longint'(1) <<< (W - 1));
  localparam int MAX_GAP = 18;
  localparam int LATENCY = W + 6;

  typedef logic signed [W-1:0] coord_t;

  typedef struct {
    coord_t left, right, bottom, top;
    coord_t ox, oy, dx, dy;
    coord_t lim;
  } ray_item_t;

  typedef struct {
    logic   hit;
    coord_t entry;
    coord_t px, py;
  } hit_report_t;

  logic   clk = 1'b0;
  logic   rst_n = 1'b0;
  logic   in_valid = 1'b0;
  logic   in_ready;
  coord_t in_box_left = '0, in_box_right = '0, in_box_bottom = '0, in_box_top = '0;
  coord_t in_origin_x = '0, in_origin_y = '0, in_direction_x = '0, in_direction_y = '0;
  coord_t in_distance_limit = '0;
  logic   out_valid;
  logic   out_ready = 1'b0;
  logic   out_hit;
  coord_t out_entry_distance, out_point_x, out_point_y;

  hit_report_t pending_reports[$];
  int          fail_count = 0;
  bit          quiet_send = 0;
  bit          quiet_recv = 0;

  ray_box_slab_intersect DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_box_left(in_box_left), .in_box_right(in_box_right),
    .in_box_bottom(in_box_bottom), .in_box_top(in_box_top),
    .in_origin_x(in_origin_x), .in_origin_y(in_origin_y),
    .in_direction_x(in_direction_x), .in_direction_y(in_direction_y),
    .in_distance_limit(in_distance_limit),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_hit(out_hit), .out_entry_distance(out_entry_distance),
    .out_point_x(out_point_x), .out_point_y(out_point_y)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Clamp a wide value to the coordinate range.
  function automatic longint clamp(longint v);
    if (v > VMAX) return VMAX;
    if (v < VMIN) return VMIN;
    return v;
  endfunction

  // Fixed-point quotient, truncated toward zero, saturated.
  function automatic longint fixed_quotient(longint num, longint den);
    logic   neg;
    longint n, d, m;
    neg = (num < 0) != (den < 0);
    n = (num < 0) ? -num : num;
    d = (den < 0) ? -den : den;
    m = (n <<< F) / d;
    if (m > VMAX) return neg ? VMIN : VMAX;
    return neg ? -m : m;
  endfunction

  // Point along the ray: product rounded toward minus infinity, sum saturated.
  function automatic longint point_along(longint o, longint d, longint t);
    longint p;
    p = (d * t) >>> F;
    return clamp(o + p);
  endfunction

  // Crossing parameters of one slab; returns 0 when a still axis misses.
  function automatic bit slab_span(longint lo, longint hi, longint o, longint d,
                                   output longint t_in, output longint t_out);
    longint a, b;
    if (d != 0) begin
      a = fixed_quotient(lo - o, d);
      b = fixed_quotient(hi - o, d);
      t_in = (a < b) ? a : b;
      t_out = (a < b) ? b : a;
      return 1;
    end
    t_in = VMIN;
    t_out = VMAX;
    return !(o < lo || o > hi);
  endfunction

  function automatic hit_report_t predict_hit(ray_item_t r);
    hit_report_t res;
    longint xi, xo, yi, yo, ent, ext;
    bit xok, yok;
    res = '{hit: 1'b0, entry: '0, px: '0, py: '0};
    xok = slab_span(r.left, r.right, r.ox, r.dx, xi, xo);
    yok = slab_span(r.bottom, r.top, r.oy, r.dy, yi, yo);
    if (!xok || !yok) return res;
    ent = (xi > yi) ? xi : yi;
    ext = (xo < yo) ? xo : yo;
    if (ext < 0 || ent > ext || ent > longint'(r.lim)) return res;
    res.hit = 1'b1;
    res.entry = coord_t'(ent);
    res.px = coord_t'(point_along(r.ox, r.dx, ent));
    res.py = coord_t'(point_along(r.oy, r.dy, ent));
    return res;
  endfunction

  // Predict each item at the edge where it is accepted.
  always @(posedge clk) begin
    ray_item_t r;
    if (rst_n && in_valid && in_ready) begin
      r = '{in_box_left, in_box_right, in_box_bottom, in_box_top,
            in_origin_x, in_origin_y, in_direction_x, in_direction_y,
            in_distance_limit};
      pending_reports.push_back(predict_hit(r));
    end
  end

  // Result side: random stalls, then compare each item with the oldest prediction.
  initial begin
    int          stall;
    hit_report_t exp_r;
    @(posedge clk iff rst_n);
    forever begin
      stall = quiet_recv ? 0 : $urandom_range(0, MAX_GAP);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      if (pending_reports.size() == 0) begin
        $error("result item with no prediction waiting");
        fail_count++;
      end else begin
        exp_r = pending_reports.pop_front();
        if (out_hit !== exp_r.hit) begin
          $error("hit: expected %0d, got %0d", exp_r.hit, out_hit);
          fail_count++;
        end
        if (out_entry_distance !== exp_r.entry) begin
          $error("entry_distance: expected %0d, got %0d", exp_r.entry, out_entry_distance);
          fail_count++;
        end
        if (out_point_x !== exp_r.px) begin
          $error("point_x: expected %0d, got %0d", exp_r.px, out_point_x);
          fail_count++;
        end
        if (out_point_y !== exp_r.py) begin
          $error("point_y: expected %0d, got %0d", exp_r.py, out_point_y);
          fail_count++;
        end
      end
    end
  end

  // Send one item after a random gap and hold it until accepted.
  task automatic send_ray(ray_item_t r);
    int gap;
    gap = quiet_send ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_box_left <= r.left;
    in_box_right <= r.right;
    in_box_bottom <= r.bottom;
    in_box_top <= r.top;
    in_origin_x <= r.ox;
    in_origin_y <= r.oy;
    in_direction_x <= r.dx;
    in_direction_y <= r.dy;
    in_distance_limit <= r.lim;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
  endtask

  function automatic coord_t rnd_small(int span);
    return coord_t'(longint'($urandom_range(0, 2 * span)) - span);
  endfunction

  function automatic coord_t rnd_word();
    return coord_t'($urandom());
  endfunction

  // Directed cases: edges of the ranges, still axes, origin inside, inverted boxes.
  task automatic test_directed();
    localparam coord_t ONE = coord_t'(1 <<< F);
    coord_t mx, mn;
    mx = coord_t'(VMAX);
    mn = coord_t'(VMIN);
    // Plain hit from the left.
    send_ray('{ONE, 3*ONE, ONE, 3*ONE, 0, 2*ONE, ONE, 0, 100*ONE});
    // Diagonal hit.
    send_ray('{ONE, 2*ONE, ONE, 2*ONE, 0, 0, ONE, ONE, mx});
    // Origin inside the box: negative entry.
    send_ray('{-ONE, ONE, -ONE, ONE, 0, 0, ONE, -ONE, mx});
    // Both axes still, origin inside: unbounded entry.
    send_ray('{-ONE, ONE, -ONE, ONE, 0, 0, 0, 0, mx});
    // Both axes still, origin outside.
    send_ray('{-ONE, ONE, -ONE, ONE, 5*ONE, 0, 0, 0, mx});
    // Still y axis, origin outside the y slab.
    send_ray('{ONE, 2*ONE, ONE, 2*ONE, 0, 5*ONE, ONE, 0, mx});
    // Box behind the ray.
    send_ray('{ONE, 2*ONE, ONE, 2*ONE, 0, 0, -ONE, -ONE, mx});
    // Entry beyond the limit.
    send_ray('{10*ONE, 11*ONE, 0, ONE, 0, ONE/2, ONE, 0, 5*ONE});
    // Negative limit with origin inside.
    send_ray('{-ONE, ONE, -ONE, ONE, 0, 0, ONE, ONE, mn});
    // Inverted boxes, moving and still.
    send_ray('{3*ONE, ONE, 3*ONE, ONE, 0, 0, ONE, ONE, mx});
    send_ray('{3*ONE, ONE, -ONE, ONE, 2*ONE, 0, 0, ONE, mx});
    // Tiny direction: quotient saturates.
    send_ray('{mx, mx, mn, mx, mn, 0, 1, 0, mx});
    send_ray('{mn, mn, mn, mx, mx, 0, -1, 0, mx});
    // Huge direction: quotient near zero, product saturation at the extremes.
    send_ray('{mn, mx, mn, mx, mn, mx, mx, mn, mx});
    send_ray('{mn, mx, mn, mx, mx, mn, mn, mx, mn});
    // Grazing a corner and edges exactly.
    send_ray('{ONE, 2*ONE, ONE, 2*ONE, 0, 0, 2*ONE, 2*ONE, mx});
    send_ray('{ONE, ONE, 0, 0, ONE, 0, 0, 0, 0});
    // Fields all ones / all zeros.
    send_ray('{'1, '1, '1, '1, '1, '1, '1, '1, '1});
    send_ray('{'0, '0, '0, '0, '0, '0, '0, '0, '0});
  endtask

  // Mostly rays aimed at boxes of modest size; a fifth is raw noise.
  task automatic test_random(int count);
    ray_item_t r;
    coord_t    cx, cy;
    for (int i = 0; i < count; i++) begin
      if (i % 200 == 0) begin
        quiet_send = ($urandom_range(0, 3) == 0);
        quiet_recv = ($urandom_range(0, 3) == 0);
      end
      if ($urandom_range(0, 4) == 0) begin
        r = '{rnd_word(), rnd_word(), rnd_word(), rnd_word(), rnd_word(),
              rnd_word(), rnd_word(), rnd_word(), rnd_word()};
      end else begin
        r.left = rnd_small(1 << (F + 4));
        r.right = ($urandom_range(0, 9) == 0) ? rnd_small(1 << (F + 4))
                                              : r.left + coord_t'($urandom_range(0, 1 << (F + 3)));
        r.bottom = rnd_small(1 << (F + 4));
        r.top = ($urandom_range(0, 9) == 0) ? rnd_small(1 << (F + 4))
                                            : r.bottom + coord_t'($urandom_range(0, 1 << (F + 3)));
        r.ox = rnd_small(1 << (F + 6));
        r.oy = rnd_small(1 << (F + 6));
        cx = (r.left >>> 1) + (r.right >>> 1);
        cy = (r.bottom >>> 1) + (r.top >>> 1);
        r.dx = ($urandom_range(0, 7) == 0) ? '0 : (cx - r.ox) + rnd_small(1 << (F + 2));
        r.dy = ($urandom_range(0, 7) == 0) ? '0 : (cy - r.oy) + rnd_small(1 << (F + 2));
        if ($urandom_range(0, 3) == 0) begin
          r.dx = r.dx >>> $urandom_range(0, 20);
          r.dy = r.dy >>> $urandom_range(0, 20);
        end
        r.lim = ($urandom_range(0, 2) == 0) ? rnd_small(1 << (F + 1)) : coord_t'(VMAX);
      end
      send_ray(r);
    end
    quiet_send = 0;
    quiet_recv = 0;
  endtask

  // Let the pipeline drain, then report.
  task automatic finish_run();
    in_valid <= 1'b0;
    wait (pending_reports.size() == 0);
    repeat (2 * LATENCY) @(posedge clk);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random(1700);
    finish_run();
  end

  // Watchdog against a hung handshake.
  initial begin
    #5000000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
